// ===== design/lmam_pkg.sv =====
package lmam_pkg;

    // default sample width in bits
    localparam int SAMPLE_WIDTH_DEF = 32;

    // width of the sample count and of every result field
    localparam int COUNT_W = 32;
    localparam int OUT_W   = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_WRITE
    } state_t;

endpackage

// ===== design/latency_min_avg_max_stats.sv =====
// Running latency statistics. Each accepted transaction on the sample channel
// carries one latency sample; only its low SAMPLE_WIDTH bits are used. The block
// keeps the running minimum, the running maximum, a sum and a 32-bit sample
// count, and returns one result transaction per sample holding the minimum,
// the floor mean (sum / count) and the maximum. When the count reaches all
// ones the count and sum freeze and saturated reads 1, while minimum and
// maximum keep tracking. The mean comes from a single shared restoring divider
// (one compare-and-subtract per cycle) that walks the SAMPLE_WIDTH+32 bits of
// the sum, so one sample occupies the block through an accept step,
// SAMPLE_WIDTH+32 divide steps and a write step into the result register;
// no new sample is taken before that. sample_stall is low only while the
// block is idle. The result register decouples the two sides: a new sample is
// taken while a finished result still waits, and the block only holds in its
// write step when the previous result has not yet been taken.
module latency_min_avg_max_stats #(
    parameter int SAMPLE_WIDTH = lmam_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // sample channel
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic [31:0]                   sample,
    // result channel
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [lmam_pkg::OUT_W-1:0]    min_value,
    output logic [lmam_pkg::OUT_W-1:0]    avg_value,
    output logic [lmam_pkg::OUT_W-1:0]    max_value,
    output logic                          saturated
);

    localparam int OUT_W   = lmam_pkg::OUT_W;
    localparam int COUNT_W = lmam_pkg::COUNT_W;
    // sum width: a sample times the largest count never overflows it
    localparam int DIV_W   = SAMPLE_WIDTH + COUNT_W;
    localparam int STEP_W  = $clog2(DIV_W);

    // sequencer
    lmam_pkg::state_t state_reg, state_next;

    // statistics state
    logic [SAMPLE_WIDTH-1:0] min_reg, min_next;
    logic [SAMPLE_WIDTH-1:0] max_reg, max_next;
    logic [DIV_W-1:0]        sum_reg, sum_next;
    logic [COUNT_W-1:0]      count_reg, count_next;

    // divider: dividend shifts out at the top, quotient bits shift in at the bottom
    logic [DIV_W-1:0]        div_reg, div_next;
    logic [COUNT_W-1:0]      rem_reg, rem_next;
    logic [STEP_W-1:0]       step_reg, step_next;

    // result register
    logic                    result_valid_reg, result_valid_next;
    logic [OUT_W-1:0]        min_out_reg, min_out_next;
    logic [OUT_W-1:0]        avg_out_reg, avg_out_next;
    logic [OUT_W-1:0]        max_out_reg, max_out_next;
    logic                    sat_out_reg, sat_out_next;

    logic [SAMPLE_WIDTH-1:0] smp;
    logic                    count_top;
    logic                    sample_take;
    logic                    result_free;
    logic [COUNT_W:0]        rem_shift;
    logic [COUNT_W:0]        rem_diff;
    logic                    q_bit;

    assign smp         = sample[SAMPLE_WIDTH-1:0];
    assign count_top   = (count_reg == '1);
    assign sample_take = sample_valid && !sample_stall;
    assign result_free = !result_valid_reg || !result_stall;

    // shared compare-and-subtract unit
    assign rem_shift = {rem_reg, div_reg[DIV_W-1]};
    assign rem_diff  = rem_shift - {1'b0, count_reg};
    assign q_bit     = !rem_diff[COUNT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= lmam_pkg::ST_IDLE;
            min_reg          <= '1;
            max_reg          <= '0;
            sum_reg          <= '0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            min_reg          <= min_next;
            max_reg          <= max_next;
            sum_reg          <= sum_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        div_reg     <= div_next;
        rem_reg     <= rem_next;
        step_reg    <= step_next;
        min_out_reg <= min_out_next;
        avg_out_reg <= avg_out_next;
        max_out_reg <= max_out_next;
        sat_out_reg <= sat_out_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        min_next          = min_reg;
        max_next          = max_reg;
        sum_next          = sum_reg;
        count_next        = count_reg;
        div_next          = div_reg;
        rem_next          = rem_reg;
        step_next         = step_reg;
        result_valid_next = result_valid_reg;
        min_out_next      = min_out_reg;
        avg_out_next      = avg_out_reg;
        max_out_next      = max_out_reg;
        sat_out_next      = sat_out_reg;
        sample_stall      = 1'b1;

        // the consumer takes the pending result
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            lmam_pkg::ST_IDLE:
            begin
                sample_stall = 1'b0;
                if (sample_valid)
                begin
                    // sum and count freeze once the count hits all ones
                    if (!count_top)
                    begin
                        count_next = count_reg + 1'b1;
                        sum_next   = sum_reg + DIV_W'(smp);
                    end
                    if (smp < min_reg)
                    begin
                        min_next = smp;
                    end
                    if (smp > max_reg)
                    begin
                        max_next = smp;
                    end
                    div_next   = sum_next;
                    rem_next   = '0;
                    step_next  = STEP_W'(DIV_W - 1);
                    state_next = lmam_pkg::ST_DIVIDE;
                end
            end

            lmam_pkg::ST_DIVIDE:
            begin
                // one restoring step per cycle
                div_next = {div_reg[DIV_W-2:0], q_bit};
                rem_next = q_bit ? rem_diff[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
                if (step_reg == '0)
                begin
                    state_next = lmam_pkg::ST_WRITE;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end

            lmam_pkg::ST_WRITE:
            begin
                // quotient never exceeds the largest sample, so the low bits suffice
                if (result_free)
                begin
                    result_valid_next = 1'b1;
                    min_out_next      = OUT_W'(min_reg);
                    avg_out_next      = OUT_W'(div_reg[SAMPLE_WIDTH-1:0]);
                    max_out_next      = OUT_W'(max_reg);
                    sat_out_next      = count_top;
                    state_next        = lmam_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lmam_pkg::ST_IDLE;
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign min_value    = min_out_reg;
    assign avg_value    = avg_out_reg;
    assign max_value    = max_out_reg;
    assign saturated    = sat_out_reg;

    // a new result only appears from the write step
    a_result_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == lmam_pkg::ST_WRITE))
        else $error("result appeared outside the write step");

    // the partial remainder stays below the divisor
    a_rem_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lmam_pkg::ST_DIVIDE) |-> (rem_reg < count_reg))
        else $error("divider remainder not below sample count");

    // once any sample is counted the minimum cannot exceed the maximum
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (min_reg <= max_reg))
        else $error("minimum above maximum");

    // an empty count implies an empty sum
    a_sum_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (sum_reg == '0))
        else $error("nonzero sum with zero count");

    // the sample channel is only taken while idle
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sample_take |=> (state_reg == lmam_pkg::ST_DIVIDE))
        else $error("sample taken without starting a division");

endmodule

// ===== tb/sv/latency_min_avg_max_stats_tb.sv =====
`timescale 1ns / 100ps

module latency_min_avg_max_stats_tb;

    localparam int SAMPLE_W     = lmam_pkg::SAMPLE_WIDTH_DEF;
    localparam int W            = lmam_pkg::OUT_W;
    localparam int RANDOM_ITEMS = 1200;
    // one sample holds the block through its accept, divide and write steps; allow margin for the tail
    localparam int DRAIN_CYCLES = SAMPLE_W + 60;
    // about 1220 samples, each through a full divide, plus gaps on both sides stay
    // well inside the watchdog limit
    localparam int CYCLE_LIMIT  = 600000;
    localparam int IDLE_PCT     = 24;

    // one result transaction as the block presents it
    typedef struct packed {
        logic [W-1:0] min_v;
        logic [W-1:0] avg_v;
        logic [W-1:0] max_v;
        logic         sat;
    } stats_t;

    // running statistics predictor plus the queue of results still owed
    class lat_stats_scoreboard;
        logic [31:0] low_mark;
        logic [31:0] high_mark;
        logic [63:0] total;
        logic [31:0] n_samples;
        logic [31:0] in_mask;
        stats_t      expected_stats[$];
        int          mismatches;
        int          results_checked;
        int          saturated_seen;

        function new(int width);
            low_mark        = '1;
            high_mark       = '0;
            total           = '0;
            n_samples       = '0;
            in_mask         = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
            mismatches      = 0;
            results_checked = 0;
            saturated_seen  = 0;
        endfunction

        function int pending();
            return expected_stats.size();
        endfunction

        // fold an accepted sample into the running state, queue the result it owes
        function void note_sample(logic [31:0] raw);
            logic [31:0] s;
            logic [63:0] quotient;
            stats_t      e;
            s = raw & in_mask;
            // count at top: sum and count freeze, min and max keep tracking
            if (n_samples != 32'hFFFF_FFFF)
            begin
                n_samples = n_samples + 32'd1;
                total     = total + {32'd0, s};
            end
            if (s < low_mark)
                low_mark = s;
            if (s > high_mark)
                high_mark = s;
            quotient = (n_samples == 32'd0) ? 64'd0 : total / {32'd0, n_samples};
            e.min_v  = low_mark;
            e.avg_v  = quotient[W-1:0];
            e.max_v  = high_mark;
            e.sat    = (n_samples == 32'hFFFF_FFFF);
            expected_stats.push_back(e);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            $display("mismatch at result %0d: %s got %h expected %h",
                     results_checked, what, got, want);
        endtask

        task check_result(stats_t got);
            stats_t want;
            if (expected_stats.size() == 0)
            begin
                report_mismatch("result with nothing outstanding", got.avg_v, '0);
                return;
            end
            want = expected_stats.pop_front();
            if (got.min_v !== want.min_v)
                report_mismatch("min_value", got.min_v, want.min_v);
            if (got.avg_v !== want.avg_v)
                report_mismatch("avg_value", got.avg_v, want.avg_v);
            if (got.max_v !== want.max_v)
                report_mismatch("max_value", got.max_v, want.max_v);
            if (got.sat !== want.sat)
                report_mismatch("saturated", {31'd0, got.sat}, {31'd0, want.sat});
            if (got.sat === 1'b1)
                saturated_seen++;
            results_checked++;
        endtask
    endclass

    logic         clk = 1'b0;
    logic         rst_n;
    logic         sample_valid;
    logic         sample_stall;
    logic [31:0]  sample;
    logic         result_valid;
    logic         result_stall;
    logic [W-1:0] min_value;
    logic [W-1:0] avg_value;
    logic [W-1:0] max_value;
    logic         saturated;

    // when set, neither side inserts gaps or stalls
    logic         no_idle = 1'b0;
    int           cycle_count = 0;
    int           samples_sent = 0;

    lat_stats_scoreboard sb;

    always #6 clk = ~clk;

    latency_min_avg_max_stats #(
        .SAMPLE_WIDTH (SAMPLE_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .min_value    (min_value),
        .avg_value    (avg_value),
        .max_value    (max_value),
        .saturated    (saturated)
    );

    // known values on every input from time zero
    initial
    begin
        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        sample       <= '0;
        result_stall <= 1'b0;
    end

    // watchdog: a hung handshake ends the run as a failure
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("watchdog expired after %0d cycles", cycle_count);
        $display("latency_min_avg_max_stats verification failed");
        $finish;
    end

    // result side: check on every accepted transaction, then pick next stall at random
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(stats_t'({min_value, avg_value, max_value, saturated}));
        result_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
    end

    // present one sample, optionally after random gap cycles, and hold it until taken;
    // returns in the time step of the accepting edge with valid still high
    task send_sample(input logic [31:0] value);
        while (!no_idle && ($urandom_range(99) < IDLE_PCT))
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= value;
        do
            @(posedge clk);
        while (sample_stall);
        sb.note_sample(value);
        samples_sent++;
    endtask

    // hold the sample side off until every outstanding result has been taken
    task wait_for_results();
        sample_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // random sample mix: full range, small latencies, near the top, single set or cleared bits,
    // typical round-trip counts and repeats of the previous value
    function automatic logic [31:0] pick_sample(logic [31:0] prev);
        int kind;
        logic [31:0] one_bit;
        kind    = $urandom_range(9);
        one_bit = 32'd1 << $urandom_range(31);
        case (kind) inside
            [0:3]:   return $urandom;
            [4:5]:   return $urandom_range(255);
            6:       return 32'hFFFF_FFFF - $urandom_range(255);
            7:       return $urandom_range(1) ? one_bit : ~one_bit;
            8:       return $urandom_range(100000, 1000);
            default: return prev;
        endcase
    endfunction

    initial
    begin
        logic [31:0] directed_samples[$];
        logic [31:0] prev;
        int          n_directed;

        sb = new(SAMPLE_W);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: first sample below the reset minimum, then the field extremes
        // (all ones leaves the minimum unchanged), a zero to pull the
        // minimum down, single-bit and alternating patterns, and a run of all ones
        // so that the sum reaches far past 32 bits and the mean climbs
        directed_samples = '{32'h0000_0100, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001,
                             32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA,
                             32'h5555_5555, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                             32'h0000_0000, 32'h0001_0000};
        // the frozen-count case needs 2^32-1 samples and lies beyond any run;
        // the predictor still models it
        n_directed = directed_samples.size();
        foreach (directed_samples[i])
            send_sample(directed_samples[i]);

        // full drain before the random part
        wait_for_results();
        @(posedge clk);

        prev = 32'h0000_0100;
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            // a long stretch with no gaps or stalls from the bench on either side
            no_idle = (k >= 450 && k < 700);
            if (k == 900)
                wait_for_results();
            prev = pick_sample(prev);
            send_sample(prev);
        end

        sample_valid <= 1'b0;
        no_idle = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        // let any stray result show up
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch("results still outstanding", sb.pending(), 0);

        $display("covered %0d samples (%0d directed), %0d results compared, %0d mismatches",
                 samples_sent, n_directed, sb.results_checked, sb.mismatches);
        $display("final min %h mean-sum %h over %0d samples, max %h, saturated results %0d",
                 sb.low_mark, sb.total, sb.n_samples, sb.high_mark, sb.saturated_seen);
        if (sb.mismatches == 0)
            $display("latency_min_avg_max_stats verification clean");
        else
            $display("latency_min_avg_max_stats verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/lmam_pkg.sv
design/latency_min_avg_max_stats.sv
tb/sv/latency_min_avg_max_stats_tb.sv
